// ----- hdl/ssm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ssm_pkg;

	localparam int unsigned CmdW    = 4;
	localparam int unsigned AngleW  = 16;
	localparam int unsigned PwmW    = 16;
	localparam int unsigned ModeW   = 3;
	localparam int unsigned CacheW  = 17;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgW    = 16;
	localparam int unsigned STdataW = 40;
	localparam int unsigned MTdataW = 56;

	localparam logic signed [AngleW-1:0] MAX_ANGLE_RST = 16'sd90;
	localparam logic signed [AngleW-1:0] MIN_ANGLE_RST = -16'sd90;
	localparam logic [PwmW-1:0]          CENTER_RST    = '0;

	localparam logic [CfgIdxW-1:0] REG_MAX_ANGLE  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_MIN_ANGLE  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_PWM_CENTER = 2'd2;

	localparam logic [ModeW-1:0] MODE_CODE_RUN      = 3'd0;
	localparam logic [ModeW-1:0] MODE_CODE_SLEEP    = 3'd1;
	localparam logic [ModeW-1:0] MODE_CODE_STOPPING = 3'd2;
	localparam logic [ModeW-1:0] MODE_CODE_FORCE    = 3'd3;
	localparam logic [ModeW-1:0] MODE_CODE_STOPPED  = 3'd4;
	localparam logic [ModeW-1:0] MODE_CODE_STALL    = 3'd5;

	typedef enum logic [CmdW-1:0] {
		CMD_TICK       = 4'd0,
		CMD_SET_TARGET = 4'd1,
		CMD_START      = 4'd2,
		CMD_WAKE       = 4'd3,
		CMD_SLEEP      = 4'd4,
		CMD_STOP       = 4'd5,
		CMD_FORCE_STOP = 4'd6,
		CMD_SAMPLE     = 4'd7,
		CMD_WRITE_PWM  = 4'd8,
		CMD_SET_MODE   = 4'd9
	} cmd_t;

	typedef enum logic [5:0] {
		MODE_RUN      = 6'b000001,
		MODE_SLEEP    = 6'b000010,
		MODE_STOPPING = 6'b000100,
		MODE_FORCE    = 6'b001000,
		MODE_STOPPED  = 6'b010000,
		MODE_STALL    = 6'b100000
	} mode_t;

	typedef struct packed {
		logic [CmdW-1:0]          cmd;
		logic signed [AngleW-1:0] angle_in;
		logic [PwmW-1:0]          pwm_in;
		logic [ModeW-1:0]         mode_in;
	} item_t;

	typedef struct packed {
		logic [PwmW-1:0]          pwm_out;
		logic                     pwm_written;
		logic [ModeW-1:0]         mode_out;
		logic signed [AngleW-1:0] target_out;
		logic signed [CacheW-1:0] angle_out;
	} result_t;

	function automatic logic [ModeW-1:0] mode_encode(input mode_t m);
		logic [ModeW-1:0] code;
		case (m)
			MODE_RUN:      code = MODE_CODE_RUN;
			MODE_SLEEP:    code = MODE_CODE_SLEEP;
			MODE_STOPPING: code = MODE_CODE_STOPPING;
			MODE_FORCE:    code = MODE_CODE_FORCE;
			MODE_STOPPED:  code = MODE_CODE_STOPPED;
			MODE_STALL:    code = MODE_CODE_STALL;
			default:       code = MODE_CODE_STOPPED;
		endcase
		return code;
	endfunction

	function automatic mode_t mode_decode(input logic [ModeW-1:0] code);
		mode_t m;
		case (code)
			MODE_CODE_RUN:      m = MODE_RUN;
			MODE_CODE_SLEEP:    m = MODE_SLEEP;
			MODE_CODE_STOPPING: m = MODE_STOPPING;
			MODE_CODE_FORCE:    m = MODE_FORCE;
			MODE_CODE_STOPPED:  m = MODE_STOPPED;
			MODE_CODE_STALL:    m = MODE_STALL;
			default:            m = MODE_STOPPED;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/ssm_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssm_core import ssm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_en,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0]    cfg_data,
	input  wire item_t              item,
	input  wire logic               advance,
	output result_t                 result
);

	logic signed [AngleW-1:0] max_angle_q;
	logic signed [AngleW-1:0] min_angle_q;
	logic [PwmW-1:0]          center_q;

	mode_t                    mode_q,   mode_d;
	logic signed [AngleW-1:0] target_q, target_d;
	logic [PwmW-1:0]          pwm_q,    pwm_d;
	logic signed [CacheW-1:0] cache_q,  cache_d;
	logic                     wrote;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_angle_q <= MAX_ANGLE_RST;
			min_angle_q <= MIN_ANGLE_RST;
			center_q    <= CENTER_RST;
		end else if (cfg_en) begin
			unique case (cfg_index)
				REG_MAX_ANGLE:  max_angle_q <= $signed(cfg_data);
				REG_MIN_ANGLE:  min_angle_q <= $signed(cfg_data);
				REG_PWM_CENTER: center_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		mode_d   = mode_q;
		target_d = target_q;
		pwm_d    = pwm_q;
		cache_d  = cache_q;
		wrote    = 1'b0;
		unique case (cmd_t'(item.cmd))
			CMD_TICK: begin
				wrote = 1'b1;
				unique case (mode_q)
					MODE_RUN:      pwm_d = center_q - $unsigned(target_q);
					MODE_SLEEP:    pwm_d = pwm_q;
					MODE_STOPPING: begin
						pwm_d = center_q;
						if (cache_q == '0)
							mode_d = MODE_STOPPED;
					end
					MODE_FORCE: begin
						pwm_d  = center_q;
						mode_d = MODE_STOPPED;
					end
					MODE_STOPPED:  pwm_d = center_q;
					MODE_STALL: begin
						pwm_d  = '0;
						mode_d = MODE_FORCE;
					end
				endcase
			end
			CMD_SET_TARGET: begin
				priority if (item.angle_in > max_angle_q)
					target_d = max_angle_q;
				else if (item.angle_in < min_angle_q)
					target_d = min_angle_q;
				else
					target_d = item.angle_in;
			end
			CMD_START: if (mode_q == MODE_STOPPED) mode_d = MODE_RUN;
			CMD_WAKE:  if (mode_q == MODE_SLEEP)   mode_d = MODE_RUN;
			CMD_SLEEP: if (mode_q == MODE_RUN)     mode_d = MODE_SLEEP;
			CMD_STOP: begin
				if (mode_q == MODE_RUN || mode_q == MODE_SLEEP)
					mode_d = MODE_STOPPING;
			end
			CMD_FORCE_STOP: mode_d = MODE_FORCE;
			CMD_SAMPLE: cache_d = $signed({1'b0, center_q}) - $signed({1'b0, pwm_q});
			CMD_WRITE_PWM: begin
				pwm_d = item.pwm_in;
				wrote = 1'b1;
			end
			CMD_SET_MODE: begin
				if (item.mode_in <= MODE_CODE_STALL)
					mode_d = mode_decode(item.mode_in);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_STOPPED;
			target_q <= '0;
			pwm_q    <= '0;
			cache_q  <= '0;
		end else if (advance) begin
			mode_q   <= mode_d;
			target_q <= target_d;
			pwm_q    <= pwm_d;
			cache_q  <= cache_d;
		end
	end

	assign result.pwm_out     = pwm_d;
	assign result.pwm_written = wrote;
	assign result.mode_out    = mode_encode(mode_d);
	assign result.target_out  = target_d;
	assign result.angle_out   = cache_d;

endmodule

`default_nettype wire

// ----- hdl/ssm_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssm_out_reg import ssm_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t result,
	input  wire logic    m_tready,
	output logic         m_tvalid,
	output logic [MTdataW-1:0] m_tdata
);

	logic    valid_s2;
	result_t result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (load)
			valid_s2 <= 1'b1;
		else if (m_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			result_s2 <= result;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000,
		result_s2.angle_out,
		result_s2.target_out,
		result_s2.mode_out,
		result_s2.pwm_written,
		result_s2.pwm_out};

endmodule

`default_nettype wire

// ----- hdl/servo_mode_sequencer_unit.sv -----
// Servo mode sequencer.
// A command word is captured in the input register, and its result word in the result register.
// One command word per cycle while m_tready does not stall the result register;
// the mode/state update lies between the input register and the result register.
// Reset (arst_n low, asynchronous): mode stopped, target, pwm and angle cache
// zero, limits +90/-90, center zero, no words held.
`timescale 1ns / 1ps
`default_nettype none

module servo_mode_sequencer_unit import ssm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [STdataW-1:0] s_tdata,   // angle_in[15:0], pwm_in[31:16], mode_in[34:32]
	input  wire logic [CmdW-1:0]    s_tuser,   // cmd[3:0]
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [MTdataW-1:0]      m_tdata,   // pwm_out[15:0], pwm_written[16],
	                                           // mode_out[19:17], target_out[35:20],
	                                           // angle_out[52:36]
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0]    cfg_data
);

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	result_t result;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd      <= s_tuser;
			item_s1.angle_in <= $signed(s_tdata[15:0]);
			item_s1.pwm_in   <= s_tdata[31:16];
			item_s1.mode_in  <= s_tdata[34:32];
		end
	end

	ssm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_s1),
		.advance   (advance),
		.result    (result)
	);

	ssm_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.result   (result),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

// ----- hdl/ssm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssm_checker import ssm_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [MTdataW-1:0] m_tdata
);

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// a word without a pwm write repeats the pwm of the word before it
	a_pwm_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) ##1 (m_tvalid && m_tready && !m_tdata[16])
		|-> m_tdata[15:0] == $past(m_tdata[15:0]))
		else $error("pwm changed without a write");

	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[19:17] != 3'd6 && m_tdata[19:17] != 3'd7)
		else $error("unused mode code on output");

	a_cache_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[52:36] != 17'h10000)
		else $error("angle cache out of range");

endmodule

bind servo_mode_sequencer_unit ssm_checker u_ssm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);

`default_nettype wire

// ----- sim/servo_mode_sequencer_unit_checker.sv -----
`timescale 1ns / 1ps

module servo_mode_sequencer_unit_checker import ssm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [STdataW-1:0] s_tdata,   // angle_in[15:0], pwm_in[31:16], mode_in[34:32]
	input  logic [CmdW-1:0]    s_tuser,   // cmd[3:0]
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [MTdataW-1:0] m_tdata,   // pwm_out[15:0], pwm_written[16],
	                                      // mode_out[19:17], target_out[35:20],
	                                      // angle_out[52:36]
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data,
	output int unsigned        pending,
	output int unsigned        errors
);

	logic signed [AngleW-1:0] lim_hi;
	logic signed [AngleW-1:0] lim_lo;
	logic [PwmW-1:0]          center;

	logic [ModeW-1:0]         mode_q;
	logic signed [AngleW-1:0] target_q;
	logic [PwmW-1:0]          pwm_q;
	logic signed [CacheW-1:0] cache_q;

	result_t expected_words[$];
	result_t want;
	result_t got;
	item_t   cmd_word;
	logic [MTdataW-CacheW-37:0] got_pad;

	function automatic result_t advance_servo(input item_t it);
		result_t r;
		r.pwm_written = 1'b0;
		case (it.cmd)
			CMD_TICK: begin
				r.pwm_written = 1'b1;
				case (mode_q)
					MODE_CODE_RUN: pwm_q = center - target_q;
					MODE_CODE_SLEEP: ;
					MODE_CODE_STOPPING: begin
						pwm_q = center;
						if (cache_q == '0)
							mode_q = MODE_CODE_STOPPED;
					end
					MODE_CODE_FORCE: begin
						pwm_q = center;
						mode_q = MODE_CODE_STOPPED;
					end
					MODE_CODE_STOPPED: pwm_q = center;
					default: begin
						pwm_q = '0;
						mode_q = MODE_CODE_FORCE;
					end
				endcase
			end
			CMD_SET_TARGET: begin
				if (it.angle_in > lim_hi)
					target_q = lim_hi;
				else if (it.angle_in < lim_lo)
					target_q = lim_lo;
				else
					target_q = it.angle_in;
			end
			CMD_START: if (mode_q == MODE_CODE_STOPPED) mode_q = MODE_CODE_RUN;
			CMD_WAKE:  if (mode_q == MODE_CODE_SLEEP) mode_q = MODE_CODE_RUN;
			CMD_SLEEP: if (mode_q == MODE_CODE_RUN) mode_q = MODE_CODE_SLEEP;
			CMD_STOP: begin
				if (mode_q == MODE_CODE_RUN || mode_q == MODE_CODE_SLEEP)
					mode_q = MODE_CODE_STOPPING;
			end
			CMD_FORCE_STOP: mode_q = MODE_CODE_FORCE;
			CMD_SAMPLE: cache_q = {1'b0, center} - {1'b0, pwm_q};
			CMD_WRITE_PWM: begin
				pwm_q = it.pwm_in;
				r.pwm_written = 1'b1;
			end
			CMD_SET_MODE: if (it.mode_in <= MODE_CODE_STALL) mode_q = it.mode_in;
			default: ;
		endcase
		r.pwm_out    = pwm_q;
		r.mode_out   = mode_q;
		r.target_out = target_q;
		r.angle_out  = cache_q;
		return r;
	endfunction

	function automatic int unsigned field_diff(input string name, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (want_v == got_v)
			return 0;
		$error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_hi   = MAX_ANGLE_RST;
			lim_lo   = MIN_ANGLE_RST;
			center   = CENTER_RST;
			mode_q   = MODE_CODE_STOPPED;
			target_q = '0;
			pwm_q    = '0;
			cache_q  = '0;
			expected_words.delete();
			pending  = 0;
			errors   = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.pwm_out     = m_tdata[15:0];
				got.pwm_written = m_tdata[16];
				got.mode_out    = m_tdata[19:17];
				got.target_out  = m_tdata[35:20];
				got.angle_out   = m_tdata[52:36];
				got_pad         = m_tdata[MTdataW-1:53];
				if (expected_words.size() == 0) begin
					$error("result word with no command outstanding: 0x%0h", m_tdata);
					errors++;
				end else begin
					want = expected_words.pop_front();
					errors += field_diff("pwm_out", want.pwm_out, got.pwm_out);
					errors += field_diff("pwm_written", want.pwm_written, got.pwm_written);
					errors += field_diff("mode_out", want.mode_out, got.mode_out);
					errors += field_diff("target_out", want.target_out, got.target_out);
					errors += field_diff("angle_out", want.angle_out, got.angle_out);
					errors += field_diff("tdata pad", '0, got_pad);
				end
			end
			if (s_tvalid && s_tready) begin
				cmd_word.cmd      = s_tuser;
				cmd_word.angle_in = s_tdata[15:0];
				cmd_word.pwm_in   = s_tdata[31:16];
				cmd_word.mode_in  = s_tdata[34:32];
				expected_words.push_back(advance_servo(cmd_word));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_ANGLE:  lim_hi = cfg_data;
					REG_MIN_ANGLE:  lim_lo = cfg_data;
					REG_PWM_CENTER: center = cfg_data;
					default: ;
				endcase
			end
			pending = expected_words.size();
		end
	end

endmodule

// ----- sim/servo_mode_sequencer_unit_test.sv -----
`timescale 1ns / 1ps

module servo_mode_sequencer_unit_test;
	import ssm_pkg::*;

	localparam logic [CmdW-1:0]  CMD_SPARE_FIRST  = 4'd10;
	localparam logic [CmdW-1:0]  CMD_SPARE_LAST   = 4'd15;
	localparam logic [ModeW-1:0] MODE_SPARE_FIRST = 3'd6;
	localparam logic [ModeW-1:0] MODE_SPARE_LAST  = 3'd7;
	localparam int unsigned      WORDS_PER_PHASE  = 140;
	localparam int unsigned      PHASES           = 6;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b1;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [STdataW-1:0] s_tdata   = '0;
	logic [CmdW-1:0]    s_tuser   = '0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [MTdataW-1:0] m_tdata;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0]    cfg_data  = '0;
	int unsigned        pending;
	int unsigned        errors;

	logic        gaps_on   = 1'b1;
	logic        stalls_on = 1'b1;
	int unsigned burst_left = 0;
	int unsigned words_sent = 0;
	logic [15:0] rx_pattern = '1;
	int unsigned rx_phase   = 0;

	servo_mode_sequencer_unit i_dut (.*);

	servo_mode_sequencer_unit_checker i_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// receiver: ready patterns from a random 16-bit word, often all ones
	always @(posedge clk) begin
		if (rx_phase == 0) begin
			rx_pattern = (stalls_on && $urandom_range(0, 2) != 0) ?
				(16'($urandom) | 16'h0001) : 16'hFFFF;
			rx_phase = 16;
		end
		rx_phase--;
		m_tready <= rx_pattern[rx_phase];
	end

	task automatic send_cmd(input logic [CmdW-1:0] cmd, input logic signed [AngleW-1:0] angle,
		input logic [PwmW-1:0] pwm, input logic [ModeW-1:0] mode_code);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			if (gaps_on) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 4))
					@(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= STdataW'({mode_code, pwm, angle});
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		words_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [CfgW-1:0] hi, input logic [CfgW-1:0] lo,
		input logic [CfgW-1:0] ctr);
		write_reg(REG_MAX_ANGLE, hi);
		write_reg(REG_MIN_ANGLE, lo);
		write_reg(REG_PWM_CENTER, ctr);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [AngleW-1:0] pick_angle();
		case ($urandom_range(0, 4))
			0, 1: return 16'($urandom);
			2: return AngleW'($urandom_range(0, 400)) - 16'd200;
			3: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return '0;
		endcase
	endfunction

	function automatic logic [PwmW-1:0] pick_pwm();
		case ($urandom_range(0, 3))
			0, 1: return 16'($urandom);
			2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return PwmW'($urandom_range(0, 2000));
		endcase
	endfunction

	task automatic send_random();
		int unsigned pick;
		logic [CmdW-1:0] cmd;
		logic [ModeW-1:0] mcode;
		pick = $urandom_range(0, 99);
		if (pick < 30)      cmd = CMD_TICK;
		else if (pick < 44) cmd = CMD_SET_TARGET;
		else if (pick < 50) cmd = CMD_START;
		else if (pick < 55) cmd = CMD_WAKE;
		else if (pick < 60) cmd = CMD_SLEEP;
		else if (pick < 66) cmd = CMD_STOP;
		else if (pick < 70) cmd = CMD_FORCE_STOP;
		else if (pick < 80) cmd = CMD_SAMPLE;
		else if (pick < 88) cmd = CMD_WRITE_PWM;
		else if (pick < 96) cmd = CMD_SET_MODE;
		else                cmd = CmdW'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		mcode = ($urandom_range(0, 9) == 0) ?
			ModeW'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)) :
			ModeW'($urandom_range(MODE_CODE_RUN, MODE_CODE_STALL));
		send_cmd(cmd, pick_angle(), pick_pwm(), mcode);
	endtask

	// run, sleep, stop, then settle to center so the stop completes
	task automatic send_stop_sequence();
		send_cmd(CMD_FORCE_STOP, pick_angle(), pick_pwm(), MODE_CODE_RUN);
		send_cmd(CMD_TICK, pick_angle(), pick_pwm(), MODE_CODE_RUN);
		send_cmd(CMD_START, pick_angle(), pick_pwm(), MODE_CODE_RUN);
		send_cmd(CMD_SET_TARGET, pick_angle(), pick_pwm(), MODE_CODE_RUN);
		repeat ($urandom_range(1, 3))
			send_cmd(CMD_TICK, pick_angle(), pick_pwm(), MODE_CODE_RUN);
		send_cmd(CMD_SLEEP, pick_angle(), pick_pwm(), MODE_CODE_RUN);
		send_cmd(CMD_TICK, pick_angle(), pick_pwm(), MODE_CODE_RUN);
		if ($urandom_range(0, 1))
			send_cmd(CMD_WAKE, pick_angle(), pick_pwm(), MODE_CODE_RUN);
		send_cmd(CMD_STOP, pick_angle(), pick_pwm(), MODE_CODE_RUN);
		send_cmd(CMD_TICK, pick_angle(), pick_pwm(), MODE_CODE_RUN);
		send_cmd(CMD_SAMPLE, pick_angle(), pick_pwm(), MODE_CODE_RUN);
		send_cmd(CMD_TICK, pick_angle(), pick_pwm(), MODE_CODE_RUN);
		send_cmd(CMD_TICK, pick_angle(), pick_pwm(), MODE_CODE_RUN);
	endtask

	initial begin
		int unsigned phase_start;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits +90/-90, center 0
		send_cmd(CMD_TICK, 16'h0000, 16'hFFFF, MODE_CODE_RUN);
		send_cmd(CMD_START, 16'hFFFF, 16'h0000, MODE_CODE_STALL);
		send_cmd(CMD_SET_TARGET, 16'h7FFF, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_SET_TARGET, 16'h8000, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_SET_TARGET, 16'd45, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_TICK, 16'h0000, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_SLEEP, 16'h0000, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_TICK, 16'h0000, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_WAKE, 16'h0000, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_STOP, 16'h0000, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_SAMPLE, 16'h0000, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_TICK, 16'h0000, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_WRITE_PWM, 16'h0000, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_SAMPLE, 16'h0000, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_TICK, 16'h0000, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_SET_MODE, 16'h0000, 16'h0000, MODE_CODE_STALL);
		send_cmd(CMD_TICK, 16'h0000, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_TICK, 16'h0000, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_FORCE_STOP, 16'h0000, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_SET_MODE, 16'h0000, 16'h0000, MODE_SPARE_LAST);
		send_cmd(CMD_SET_MODE, 16'h0000, 16'h0000, MODE_SPARE_FIRST);
		send_cmd(CMD_WRITE_PWM, 16'h0000, 16'hFFFF, MODE_CODE_RUN);
		send_cmd(CMD_SAMPLE, 16'h0000, 16'h0000, MODE_CODE_RUN);
		send_cmd(CMD_SPARE_LAST, 16'hFFFF, 16'hFFFF, MODE_SPARE_LAST);
		send_cmd(CMD_SPARE_FIRST, 16'h0000, 16'h0000, MODE_CODE_RUN);

		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				0: set_limits(16'h7FFF, 16'h8000, 16'hFFFF);
				1: set_limits(16'h8000, 16'h7FFF, 16'h0000);
				2: set_limits(16'h0000, 16'h0000, 16'h8000);
				3: set_limits(16'($urandom), 16'($urandom), 16'($urandom));
				4: set_limits(16'd100, -16'd100, 16'd1500);
				default: set_limits(MAX_ANGLE_RST, MIN_ANGLE_RST, CENTER_RST);
			endcase
			gaps_on   = !(phase == 2 || phase == 5);
			stalls_on = (phase != 2);
			if (phase == 0) begin
				// largest positive angle cache
				send_cmd(CMD_WRITE_PWM, 16'h0000, 16'h0000, MODE_CODE_RUN);
				send_cmd(CMD_SAMPLE, 16'h0000, 16'h0000, MODE_CODE_RUN);
			end
			phase_start = words_sent;
			while (words_sent - phase_start < WORDS_PER_PHASE) begin
				if ($urandom_range(0, 19) == 0)
					send_stop_sequence();
				else
					send_random();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
